// ----- rtl/core/stos_pkg.sv -----
// ----------------------------------------------------------------------------
// stos_pkg
// Shared types and constants for the sparse tensor order-slice extractor.
// ----------------------------------------------------------------------------
package stos_pkg;

  // Field widths
  localparam int RUN_W   = 30;
  localparam int VALUE_W = 64;
  localparam int ROW_W   = 12;
  localparam int COL_W   = 12;
  localparam int ORD_W   = 6;
  localparam int DIM_W   = 13;   // num_rows / num_cols register width
  localparam int NORD_W  = 7;    // num_orders register width
  localparam int CFG_W   = 13;   // widest register
  localparam int CFG_IDX_W = 2;

  // Dimension caps
  localparam int MAX_COLS   = 4096;
  localparam int MAX_ORDERS = 64;
  localparam logic [DIM_W-1:0] COLS_CAP =
    DIM_W'((MAX_COLS > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_COLS);
  localparam logic [NORD_W-1:0] ORDS_CAP =
    NORD_W'((MAX_ORDERS > (2**NORD_W - 1)) ? (2**NORD_W - 1) : MAX_ORDERS);

  // Restoring divider: one quotient bit per cycle over the start index
  localparam int DIV_STEPS = RUN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ORDERS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SELECTED_ORDER = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic start_div1;   // latch run start, divide by order count
    logic div_step;     // one divider iteration
    logic start_div2;   // keep order, divide quotient by column count
    logic advance;      // step position by one element and emit
    logic commit;       // take divided position and emit
  } stos_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;     // current step is the last of a pass
    logic out_busy;     // result register full and stalled
  } stos_sts_t;

endpackage

// ----- rtl/core/stos_ctrl.sv -----
// ----------------------------------------------------------------------------
// stos_ctrl
// Sequencer: accepts transactions and steps the divider through both passes.
// ----------------------------------------------------------------------------
module stos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_first_in_run,
  output logic                in_stall,
  output stos_pkg::stos_cmd_t cmd,
  input  stos_pkg::stos_sts_t sts
);
  import stos_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV1  = 5'b00010,
    S_LOAD2 = 5'b00100,
    S_DIV2  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall = (state_r != S_IDLE) || sts.out_busy;
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_first_in_run) begin
            cmd.start_div1 = 1'b1;
            state_nxt      = S_DIV1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_LOAD2;
      end
      S_LOAD2: begin
        cmd.start_div2 = 1'b1;
        state_nxt      = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hold until the result register can take the transaction
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/stos_dpath.sv -----
// ----------------------------------------------------------------------------
// stos_dpath
// Configuration, position counters, shared divider and result register.
// ----------------------------------------------------------------------------
module stos_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [stos_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stos_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [stos_pkg::RUN_W-1:0]           in_run_start,
  input  logic [stos_pkg::VALUE_W-1:0]         in_value,
  input  stos_pkg::stos_cmd_t                  cmd,
  output stos_pkg::stos_sts_t                  sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stos_pkg::ROW_W-1:0]           out_row,
  output logic [stos_pkg::COL_W-1:0]           out_col,
  output logic [stos_pkg::VALUE_W-1:0]         out_value_res
);
  import stos_pkg::*;

  // configuration
  logic [DIM_W-1:0]  num_rows_r, num_cols_r;
  logic [NORD_W-1:0] num_orders_r;
  logic [ORD_W-1:0]  sel_r;
  logic [DIM_W-1:0]  eff_cols;
  logic [NORD_W-1:0] eff_ords;

  // position
  logic [ROW_W-1:0] row_pos_r;
  logic [COL_W-1:0] col_pos_r;
  logic [ORD_W-1:0] ord_pos_r;

  // divider
  logic [RUN_W-1:0] dvd_r;
  logic [DIM_W-1:0] rem_r, divisor_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIM_W:0]   trial;
  logic             qbit;
  logic [ORD_W-1:0] ord_hold_r;
  logic [VALUE_W-1:0] val_hold_r;

  // result register
  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [VALUE_W-1:0] out_value_r;

  // next position
  logic [ORD_W-1:0] ord_inc, new_ord;
  logic [COL_W-1:0] col_inc, new_col;
  logic [ROW_W-1:0] new_row;
  logic             ord_wrap, col_wrap, hit, load_out;

  always_comb begin
    eff_cols = num_cols_r;
    if (num_cols_r == '0) eff_cols = DIM_W'(1);
    else if (num_cols_r > COLS_CAP) eff_cols = COLS_CAP;
    eff_ords = num_orders_r;
    if (num_orders_r == '0) eff_ords = NORD_W'(1);
    else if (num_orders_r > ORDS_CAP) eff_ords = ORDS_CAP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r   <= DIM_W'(1);
      num_cols_r   <= DIM_W'(1);
      num_orders_r <= NORD_W'(1);
      sel_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ROWS:       num_rows_r   <= cfg_wdata;
        REG_NUM_COLS:       num_cols_r   <= cfg_wdata;
        REG_NUM_ORDERS:     num_orders_r <= cfg_wdata[NORD_W-1:0];
        REG_SELECTED_ORDER: sel_r        <= cfg_wdata[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring division step
  assign trial = {rem_r, dvd_r[RUN_W-1]};
  assign qbit  = trial >= {1'b0, divisor_r};
  assign sts.div_last = cnt_r == CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start_div1 || cmd.start_div2) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div1) begin
      dvd_r      <= in_run_start;
      rem_r      <= '0;
      divisor_r  <= DIM_W'(eff_ords);
      val_hold_r <= in_value;
    end else if (cmd.start_div2) begin
      // quotient of the first pass stays in dvd_r as the next dividend
      ord_hold_r <= rem_r[ORD_W-1:0];
      rem_r      <= '0;
      divisor_r  <= eff_cols;
    end else if (cmd.div_step) begin
      rem_r <= qbit ? DIM_W'(trial - {1'b0, divisor_r}) : trial[DIM_W-1:0];
      dvd_r <= {dvd_r[RUN_W-2:0], qbit};
    end
  end

  // position update
  always_comb begin
    ord_inc  = ord_pos_r + ORD_W'(1);
    col_inc  = col_pos_r + COL_W'(1);
    ord_wrap = {1'b0, ord_inc} >= eff_ords;
    col_wrap = {1'b0, col_inc} >= eff_cols;
    if (cmd.commit) begin
      new_row = dvd_r[ROW_W-1:0];
      new_col = rem_r[COL_W-1:0];
      new_ord = ord_hold_r;
    end else begin
      new_row = row_pos_r;
      new_col = col_pos_r;
      new_ord = ord_inc;
      if (ord_wrap) begin
        new_ord = '0;
        new_col = col_inc;
        if (col_wrap) begin
          new_col = '0;
          new_row = row_pos_r + ROW_W'(1);
        end
      end
    end
    hit = ({1'b0, sel_r} < eff_ords) && (new_ord == sel_r) &&
          ({1'b0, new_row} < num_rows_r);
  end

  assign load_out = cmd.advance || cmd.commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      ord_pos_r <= '0;
    end else if (load_out) begin
      row_pos_r <= new_row;
      col_pos_r <= new_col;
      ord_pos_r <= new_ord;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= hit;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row_r   <= new_row;
      out_col_r   <= new_col;
      out_value_r <= cmd.commit ? val_hold_r : in_value;
    end
  end

  assign sts.out_busy  = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value_res = out_value_r;

endmodule

// ----- rtl/core/sparse_tensor_order_slice.sv -----
// ----------------------------------------------------------------------------
// sparse_tensor_order_slice
// Extracts one order slice from a run-length stored [row][column][order] array.
// ----------------------------------------------------------------------------
// Stored values arrive one transaction at a time. A value that continues a
// run steps the (row, column, order) position by one element: a new
// transaction is accepted on every cycle while the result register is free
// or being emptied. A value that starts a run is split into row, column and
// order by a shared restoring divider, one quotient bit per cycle: a 30-step
// pass by the order count, a reload, a 30-step pass by the column count, then
// the result is written, and no new value is accepted until then (the write
// waits while the result side stalls). Only values whose order equals
// selected_order, with a row below num_rows, produce a result transaction
// carrying row, column and the untouched value; zero-filling of the dense
// slice is left to the consumer. A zero num_cols or num_orders acts as one.
// Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module sparse_tensor_order_slice (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [stos_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stos_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_first_in_run,
  input  logic [stos_pkg::RUN_W-1:0]     in_run_start,
  input  logic [stos_pkg::VALUE_W-1:0]   in_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [stos_pkg::ROW_W-1:0]     out_row,
  output logic [stos_pkg::COL_W-1:0]     out_col,
  output logic [stos_pkg::VALUE_W-1:0]   out_value_res
);
  import stos_pkg::*;

  stos_cmd_t cmd;
  stos_sts_t sts;

  // sequencer: accept, run the divider passes, commit
  stos_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_first_in_run (in_first_in_run),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .sts             (sts)
  );

  // counters, divider and the result register that parts the two sides
  stos_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_run_start  (in_run_start),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value_res (out_value_res)
  );

endmodule

// ----- tb/sv/sparse_tensor_order_slice_check.sv -----
// ----------------------------------------------------------------------------
// sparse_tensor_order_slice_check
// Watches the configuration port and both channels of the order-slice
// extractor, tracks the element position of every accepted value and checks
// each result transaction against the oldest slice entry still due.
// ----------------------------------------------------------------------------
module sparse_tensor_order_slice_check
  import stos_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_first_in_run,
  input  logic [RUN_W-1:0]     in_run_start,
  input  logic [VALUE_W-1:0]   in_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ROW_W-1:0]     out_row,
  input  logic [COL_W-1:0]     out_col,
  input  logic [VALUE_W-1:0]   out_value_res,
  output int                   fail_count,
  output int                   pending,
  output int                   matched
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
  } slice_entry_t;

  slice_entry_t slice_due[$];

  logic [DIM_W-1:0]  rows_reg;
  logic [DIM_W-1:0]  cols_reg;
  logic [NORD_W-1:0] ords_reg;
  logic [ORD_W-1:0]  sel_reg;

  logic [ROW_W-1:0] row_at;
  logic [COL_W-1:0] col_at;
  logic [ORD_W-1:0] ord_at;

  initial begin
    fail_count = 0;
    matched    = 0;
  end

  assign pending = slice_due.size();

  function automatic int unsigned cols_in_use();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return cols_reg;
  endfunction

  function automatic int unsigned ords_in_use();
    if (ords_reg == 0) return 1;
    if (ords_reg > MAX_ORDERS) return MAX_ORDERS;
    return ords_reg;
  endfunction

  // Move the position to the element this value belongs to, and queue the
  // slice entry when that element lies in the selected order and the matrix.
  task automatic locate_element(input logic first, input logic [RUN_W-1:0] start,
                                input logic [VALUE_W-1:0] value);
    int unsigned cols;
    int unsigned ords;
    longint unsigned plane;
    longint unsigned rem;
    slice_entry_t entry;
    cols = cols_in_use();
    ords = ords_in_use();
    if (first) begin
      plane  = longint'(cols) * longint'(ords);
      rem    = longint'(start) % plane;
      row_at = ROW_W'(longint'(start) / plane);
      ord_at = ORD_W'(rem % ords);
      col_at = COL_W'(rem / ords);
    end else begin
      // order wraps within its own 6 bits before the comparison
      ord_at = ord_at + 1'b1;
      if (ord_at >= ords) begin
        ord_at = '0;
        col_at = col_at + 1'b1;
        if (col_at >= cols) begin
          col_at = '0;
          row_at = row_at + 1'b1;
        end
      end
    end
    if (sel_reg < ords && ord_at == sel_reg && row_at < rows_reg) begin
      entry.row   = row_at;
      entry.col   = col_at;
      entry.value = value;
      slice_due.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    slice_entry_t due;
    if (!rst_n) begin
      rows_reg = 1;
      cols_reg = 1;
      ords_reg = 1;
      sel_reg  = 0;
      row_at   = '0;
      col_at   = '0;
      ord_at   = '0;
      slice_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (slice_due.size() == 0) begin
          $error("unexpected result: row %0d col %0d value %h", out_row, out_col,
                 out_value_res);
          fail_count++;
        end else begin
          due = slice_due.pop_front();
          if (out_row !== due.row) begin
            $error("row: expected %0d, actual %0d", due.row, out_row);
            fail_count++;
          end
          if (out_col !== due.col) begin
            $error("col: expected %0d, actual %0d", due.col, out_col);
            fail_count++;
          end
          if (out_value_res !== due.value) begin
            $error("value_res: expected %h, actual %h", due.value, out_value_res);
            fail_count++;
          end
          matched++;
        end
      end
      if (in_valid && !in_stall)
        locate_element(in_first_in_run, in_run_start, in_value);
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_ROWS:       rows_reg = cfg_wdata[DIM_W-1:0];
          REG_NUM_COLS:       cols_reg = cfg_wdata[DIM_W-1:0];
          REG_NUM_ORDERS:     ords_reg = cfg_wdata[NORD_W-1:0];
          REG_SELECTED_ORDER: sel_reg  = cfg_wdata[ORD_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/sparse_tensor_order_slice_test.sv -----
// ----------------------------------------------------------------------------
// sparse_tensor_order_slice_test
// Drives stored values through the order-slice extractor under a series of
// array shapes and selected orders, with random gaps on the sender side and
// random stalls on the receiver side; the checker beside the block predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module sparse_tensor_order_slice_test;
  timeunit 1ns;
  timeprecision 1ps;
  import stos_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 100;     // settle time for a run start still in the divider passes
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 111;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_first_in_run = 1'b0;
  logic [RUN_W-1:0]     in_run_start = '0;
  logic [VALUE_W-1:0]   in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic [VALUE_W-1:0]   out_value_res;

  int fail_count;
  int pending;
  int matched;
  int cycle_count = 0;
  int items_sent = 0;
  bit calm = 1'b0;        // phase without idling on either side

  // Shape last written, used to aim run starts inside the array
  int unsigned shape_rows = 1;
  int unsigned shape_cols = 1;
  int unsigned shape_ords = 1;

  always #2 clk = ~clk;

  sparse_tensor_order_slice DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_in_run (in_first_in_run),
    .in_run_start    (in_run_start),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value_res   (out_value_res)
  );

  sparse_tensor_order_slice_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_in_run (in_first_in_run),
    .in_run_start    (in_run_start),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_value_res   (out_value_res),
    .fail_count      (fail_count),
    .pending         (pending),
    .matched         (matched)
  );

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[sparse_tensor_order_slice] ERROR");
      $finish;
    end
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Receiver: hold stall for a random number of cycles before each result,
  // then drop it until the result transaction has gone through.
  initial begin
    int n;
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Sender: idle for a random gap, then present the value and hold it
  // until the transaction is taken. Valid stays high across a zero gap.
  task automatic send_item(input logic first, input logic [RUN_W-1:0] start,
                           input logic [VALUE_W-1:0] value);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_in_run <= first;
    in_run_start    <= start;
    in_value        <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Drop valid, wait for every due result, then let a divider pass that
  // produces nothing run out before the registers are touched.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers; junk fills the bits above the narrow ones.
  task automatic set_shape(input int unsigned rows, input int unsigned cols,
                           input int unsigned ords, input int unsigned sel,
                           input bit junk);
    logic [CFG_W-1:0] upper;
    upper = junk ? CFG_W'($urandom) : '0;
    cfg_we    <= 1'b1;
    cfg_index <= REG_NUM_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= REG_NUM_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_NUM_ORDERS;
    cfg_wdata <= {upper[CFG_W-1:NORD_W], NORD_W'(ords)};
    @(posedge clk);
    cfg_index <= REG_SELECTED_ORDER;
    cfg_wdata <= {upper[CFG_W-1:ORD_W], ORD_W'(sel)};
    @(posedge clk);
    cfg_we <= 1'b0;
    shape_rows = (rows == 0) ? 1 : ((rows > 4096) ? 4096 : rows);
    shape_cols = (cols == 0) ? 1 : ((cols > MAX_COLS) ? MAX_COLS : cols);
    shape_ords = (ords[NORD_W-1:0] == 0) ? 1 :
                 ((ords[NORD_W-1:0] > MAX_ORDERS) ? MAX_ORDERS : ords[NORD_W-1:0]);
  endtask

  // Mostly well-formed runs: a run start inside the array followed by a
  // stretch of continuing values; the rest are wild starts and noise.
  task automatic send_runs(input int count);
    int sent;
    int pick;
    int len;
    longint unsigned span;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        span = longint'(shape_rows) * shape_cols * shape_ords;
        if (span > (64'd1 << RUN_W)) span = 64'd1 << RUN_W;
        send_item(1'b1, RUN_W'($urandom_range(0, int'(span - 1))), {$urandom, $urandom});
        len = $urandom_range(0, 2 * shape_ords + 2);
        repeat (len) send_item(1'b0, RUN_W'($urandom), {$urandom, $urandom});
        sent += len + 1;
      end else if (pick < 90) begin
        send_item(1'b1, RUN_W'($urandom), {$urandom, $urandom});
        sent++;
      end else begin
        send_item(1'($urandom), RUN_W'($urandom), {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned rows;
    int unsigned cols;
    int unsigned ords;
    int unsigned sel;
    bit junk;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset shape: values before any run start count on from the origin
    send_item(1'b0, '0, '0);
    send_item(1'b0, '1, '1);
    send_item(1'b1, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();

    // Zero columns and orders act as one; a huge start wraps the row
    set_shape(8191, 0, 0, 0, 1'b0);
    send_item(1'b1, '1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(1'b0, '0, '0);
    send_item(1'b1, '0, 64'h0123_4567_89AB_CDEF);
    wait_idle();

    // Oversized columns and orders clamp to the caps; last order selected
    set_shape(4, 8191, 127, 63, 1'b0);
    send_item(1'b1, RUN_W'(((1 * 4096) + 4095) * 64 + 62), 64'hA5A5_A5A5_5A5A_5A5A);
    send_item(1'b0, '0, 64'h8000_0000_0000_0001);
    send_item(1'b0, '1, 64'h7FFF_FFFF_FFFF_FFFE);
    send_item(1'b1, RUN_W'(63), 64'hDEAD_BEEF_CAFE_F00D);
    wait_idle();

    // Selected order equal to the order count: nothing comes out
    set_shape(16, 3, 5, 5, 1'b0);
    send_item(1'b1, RUN_W'(4), 64'h1111_2222_3333_4444);
    send_item(1'b0, '0, 64'h5555_6666_7777_8888);
    wait_idle();

    // Stepping past the last row leaves the matrix
    set_shape(2, 2, 2, 1, 1'b0);
    send_item(1'b1, RUN_W'(7), 64'h0F0F_0F0F_0F0F_0F0F);
    send_item(1'b0, '0, 64'hF0F0_F0F0_F0F0_F0F0);
    send_item(1'b0, '0, 64'h1234_5678_9ABC_DEF0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      junk = $urandom_range(0, 1);
      case (p % 7)
        0: begin
          rows = $urandom_range(1, 16);
          cols = $urandom_range(1, 8);
          ords = $urandom_range(1, 8);
          sel  = $urandom_range(0, ords - 1);
        end
        1: begin
          rows = 8191;
          cols = 0;
          ords = 0;
          sel  = $urandom_range(0, 1) ? 0 : $urandom_range(0, 63);
        end
        2: begin
          rows = $urandom_range(1, 64);
          cols = $urandom_range(4096, 8191);
          ords = $urandom_range(64, 127);
          sel  = $urandom_range(0, 63);
        end
        3: begin
          rows = (p < 7) ? 0 : $urandom_range(0, 8191);
          cols = $urandom_range(1, 4);
          ords = $urandom_range(1, 4);
          sel  = $urandom_range(0, ords - 1);
        end
        4: begin
          rows = $urandom_range(1, 32);
          cols = $urandom_range(1, 8);
          ords = $urandom_range(1, 8);
          sel  = $urandom_range(ords, 63);
        end
        5: begin
          rows = 4096;
          cols = $urandom_range(1, 16);
          ords = $urandom_range(1, 16);
          sel  = $urandom_range(0, ords - 1);
        end
        default: begin
          rows = $urandom_range(0, 8191);
          cols = $urandom_range(0, 8191);
          ords = $urandom_range(0, 127);
          sel  = $urandom_range(0, 63);
        end
      endcase
      calm = (p % 4 == 3);
      set_shape(rows, cols, ords, sel, junk);
      send_runs(PHASE_ITEMS);
      wait_idle();
    end

    calm = 1'b0;
    $display("Sent %0d values over %0d array shapes; %0d slice entries checked.",
             items_sent, RANDOM_PHASES + 5, matched);
    if (fail_count == 0 && pending == 0) begin
      $display("[sparse_tensor_order_slice] OK");
    end else begin
      $display("[sparse_tensor_order_slice] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/stos_pkg.sv
rtl/core/stos_ctrl.sv
rtl/core/stos_dpath.sv
rtl/core/sparse_tensor_order_slice.sv
tb/sv/sparse_tensor_order_slice_check.sv
tb/sv/sparse_tensor_order_slice_test.sv
